@@ sv/sitda_pkg.sv @@
// ----------------------------------------------------------------------------
// sitda_pkg
// Shared types and constants for the signed integer to decimal text unit.
// ----------------------------------------------------------------------------
package sitda_pkg;

  localparam int unsigned DigitW = 4;

  // double dabble correction: a digit of five or more gets three added
  localparam logic [DigitW-1:0] DABBLE_MIN = 4'd5;
  localparam logic [DigitW-1:0] DABBLE_ADD = 4'd3;

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;

  // per-cycle command to every digit cell
  typedef struct packed {
    logic clear;   // zero the digit
    logic dabble;  // correct and shift one binary bit in from below
    logic shift;   // take the digit of the lower neighbor
  } sitda_ctrl_t;

endpackage

@@ sv/sitda_digit_cell.sv @@
// ----------------------------------------------------------------------------
// sitda_digit_cell
// One decimal digit of the conversion chain: shift-add-3 step while the
// binary magnitude streams in, plain shift toward the top while digits leave.
// ----------------------------------------------------------------------------
module sitda_digit_cell
  import sitda_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sitda_ctrl_t       ctrl_i,
  input  logic              bit_i,
  input  logic [DigitW-1:0] digit_i,
  output logic              bit_o,
  output logic [DigitW-1:0] digit_o
);

  logic [DigitW-1:0] digit_q, digit_d;
  logic [DigitW-1:0] adj;

  always_comb begin
    adj = (digit_q >= DABBLE_MIN) ? digit_q + DABBLE_ADD : digit_q;
    digit_d = digit_q;
    if (ctrl_i.clear) begin
      digit_d = '0;
    end else if (ctrl_i.dabble) begin
      digit_d = {adj[DigitW-2:0], bit_i};
    end else if (ctrl_i.shift) begin
      digit_d = digit_i;
    end
  end

  assign bit_o   = adj[DigitW-1];
  assign digit_o = digit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      digit_q <= '0;
    end else begin
      digit_q <= digit_d;
    end
  end

endmodule

@@ sv/signed_int_to_decimal_ascii_unit.sv @@
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_unit
// Signed integer to decimal ASCII text, most significant digit first, with a
// leading minus for negative values and a flag on the last character.
// ----------------------------------------------------------------------------
// A new word is taken only once the last digit of the previous word has been
// loaded into the output register, so a stalled output also holds the input.
// The magnitude is first shifted bit by bit through the chain of digit cells,
// then the digits are shifted out of the top cell as the output takes them,
// leading zeros being dropped at one per cycle.
// Reset clears the control state and all digit cells; no clearing pass.
module signed_int_to_decimal_ascii_unit
  import sitda_pkg::*;
#(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [VALUE_WIDTH-1:0] value_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [7:0]                    character_o,
  output logic                          last_o
);

  // digits of 2^VALUE_WIDTH, enough for 2^(VALUE_WIDTH-1), log10(2) ~ 0.30103
  localparam int unsigned NUM_DIGITS = (VALUE_WIDTH * 30103) / 100000 + 1;
  localparam int unsigned BitCntW    = $clog2(VALUE_WIDTH);
  localparam int unsigned DigCntW    = $clog2(NUM_DIGITS + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_SIGN,
    ST_DIGITS
  } state_e;

  state_e               state_q;
  logic [VALUE_WIDTH-1:0] mag_q;
  logic [BitCntW-1:0]   bit_cnt_q;
  logic [DigCntW-1:0]   dig_cnt_q;
  logic                 started_q;
  logic                 out_valid_q;
  logic [7:0]           character_q;
  logic                 last_q;

  sitda_ctrl_t          ctrl;
  logic [DigitW-1:0]    digit [NUM_DIGITS];
  logic                 carry [NUM_DIGITS];
  logic [DigitW-1:0]    top_digit;
  logic                 in_accept;
  logic                 can_emit;
  logic                 skip;
  logic                 value_neg;
  logic                 out_load;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_accept  = in_valid_i && in_ready_o;
  assign can_emit   = !out_valid_q || out_ready_i;
  assign top_digit  = digit[NUM_DIGITS-1];
  assign value_neg  = value_i[VALUE_WIDTH-1];

  // leading zero, not the final digit: drop it
  assign skip = !started_q && (top_digit == '0) && (dig_cnt_q > DigCntW'(1));

  // a new character enters the output register
  assign out_load = can_emit && ((state_q == ST_SIGN) || (state_q == ST_DIGITS && !skip));

  always_comb begin
    ctrl.clear  = in_accept;
    ctrl.dabble = (state_q == ST_CONV);
    ctrl.shift  = (state_q == ST_DIGITS) && (skip || can_emit);
  end

  for (genvar i = 0; i < NUM_DIGITS; i++) begin : g_cell
    sitda_digit_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .bit_i   ((i == 0) ? mag_q[VALUE_WIDTH-1] : carry[(i == 0) ? 0 : i-1]),
      .digit_i ((i == 0) ? '0 : digit[(i == 0) ? 0 : i-1]),
      .bit_o   (carry[i]),
      .digit_o (digit[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      bit_cnt_q   <= '0;
      dig_cnt_q   <= '0;
      started_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_accept) begin
            // most negative value negates to its own unsigned magnitude
            mag_q     <= value_neg ? (~value_i + 1'b1) : value_i;
            started_q <= value_neg;
            bit_cnt_q <= BitCntW'(VALUE_WIDTH - 1);
            state_q   <= ST_CONV;
          end
        end
        ST_CONV: begin
          mag_q     <= mag_q << 1;
          bit_cnt_q <= bit_cnt_q - 1'b1;
          if (bit_cnt_q == '0) begin
            dig_cnt_q <= DigCntW'(NUM_DIGITS);
            state_q   <= started_q ? ST_SIGN : ST_DIGITS;
            started_q <= 1'b0;
          end
        end
        ST_SIGN: begin
          if (can_emit) begin
            character_q <= CHAR_MINUS;
            last_q      <= 1'b0;
            state_q     <= ST_DIGITS;
          end
        end
        ST_DIGITS: begin
          if (skip) begin
            dig_cnt_q <= dig_cnt_q - 1'b1;
          end else if (can_emit) begin
            character_q <= CHAR_ZERO + {4'b0, top_digit};
            last_q      <= (dig_cnt_q == DigCntW'(1));
            started_q   <= 1'b1;
            dig_cnt_q   <= dig_cnt_q - 1'b1;
            if (dig_cnt_q == DigCntW'(1)) begin
              state_q <= ST_IDLE;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign character_o = character_q;
  assign last_o      = last_q;

`ifndef SYNTH
  a_char_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (character_o == CHAR_MINUS ||
                     (character_o >= CHAR_ZERO && character_o <= CHAR_NINE)))
    else $error("character outside '-' and '0'..'9'");

  a_minus_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && character_o == CHAR_MINUS) |-> !last_o)
    else $error("minus flagged as last character");

  a_accept_starts_conv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> (state_q == ST_CONV))
    else $error("accepted word did not start conversion");

  a_digits_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIGITS) |-> (dig_cnt_q != '0))
    else $error("digit phase with no digits left");

  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIGITS && !skip && can_emit && dig_cnt_q == DigCntW'(1))
      |=> (out_valid_o && last_o && state_q == ST_IDLE))
    else $error("final digit not flagged as last");
`endif

endmodule

@@ tb/signed_int_to_decimal_ascii_unit_tb.sv @@
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_unit_tb
// Feeds signed 32-bit values into the decimal text unit and checks every
// character and last flag against a behavioral speller. Both handshakes idle
// at random, and one long output hold-off backs the unit up into its input.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii_unit_tb;
  import sitda_pkg::*;

  localparam int unsigned RANDOM_WORDS    = 400;
  localparam int unsigned HOLD_OFF_CYCLES = 400;
  localparam int unsigned DRAIN_CYCLES    = 80;
  localparam int unsigned IDLE_LIMIT      = 5000;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } text_char_t;

  class text_scoreboard;
    text_char_t  pending_chars[$];
    int unsigned errors;

    // spell the value in decimal, minus first, most significant digit next
    function void note_value(logic [31:0] v);
      logic [31:0] mag;
      logic [3:0]  digits[$];
      text_char_t  c;
      mag = v[31] ? (~v + 32'd1) : v;
      do begin
        digits.push_back(4'(mag % 32'd10));
        mag = mag / 32'd10;
      end while (mag != 32'd0);
      if (v[31]) begin
        c.ch   = CHAR_MINUS;
        c.last = 1'b0;
        pending_chars.push_back(c);
      end
      for (int i = digits.size() - 1; i >= 0; i--) begin
        c.ch   = CHAR_ZERO + {4'd0, digits[i]};
        c.last = (i == 0);
        pending_chars.push_back(c);
      end
    endfunction

    function void check_char(logic [7:0] ch, logic last);
      text_char_t want;
      if (pending_chars.size() == 0) begin
        $display("%0t: unexpected character, expected none, got %h last %b",
                 $time, ch, last);
        errors++;
        return;
      end
      want = pending_chars.pop_front();
      if (ch !== want.ch) begin
        $display("%0t: character mismatch, expected %h, got %h", $time, want.ch, ch);
        errors++;
      end
      if (last !== want.last) begin
        $display("%0t: last mismatch, expected %b, got %b", $time, want.last, last);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  logic [31:0] value_i     = 32'd0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [7:0]  character_o;
  logic        last_o;

  text_scoreboard board;
  bit             hold_off_req  = 1'b0;
  bit             hold_off_done = 1'b0;
  bit             quiet_input   = 1'b0;
  int unsigned    idle_cycles   = 0;

  signed_int_to_decimal_ascii_unit #(
    .VALUE_WIDTH(32)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .value_i    (value_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .character_o(character_o),
    .last_o     (last_o)
  );

  always #5 clk_i = ~clk_i;

  // mostly short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [31:0] random_value();
    int unsigned pick;
    int unsigned k;
    logic [31:0] top;
    logic [31:0] mag;
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      return $urandom();
    end
    if (pick < 75) begin
      // magnitude with a chosen number of digits at most
      k   = $urandom_range(1, 9);
      top = 32'd1;
      repeat (k) top = top * 32'd10;
      mag = $urandom() % top;
    end else if (pick < 90) begin
      // powers of ten and their neighbors
      k   = $urandom_range(0, 9);
      top = 32'd1;
      repeat (k) top = top * 32'd10;
      mag = top + 32'($urandom_range(0, 2)) - 32'd1;
    end else begin
      case ($urandom_range(0, 5))
        0: return 32'h7FFF_FFFF;
        1: return 32'h8000_0000;
        2: return 32'h8000_0001;
        3: return 32'h7FFF_FFFE;
        4: return 32'h0000_0000;
        default: return 32'hFFFF_FFFF;
      endcase
    end
    return $urandom_range(0, 1) ? (~mag + 32'd1) : mag;
  endfunction

  // called right after the previous word was taken
  task automatic send_value(input logic [31:0] v);
    int unsigned gap;
    gap = quiet_input ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    value_i    <= v;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) board.note_value(value_i);
    if (rst_ni && out_valid_o && out_ready_i) board.check_char(character_o, last_o);
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles == IDLE_LIMIT) begin
        $display("%0t: no word moved for %0d cycles", $time, IDLE_LIMIT);
        $display("FAIL signed_int_to_decimal_ascii_unit");
        $finish;
      end
    end
  end

  initial begin : ready_driver
    int unsigned run_len;
    int unsigned stall_len;
    wait (rst_ni);
    forever begin
      if (hold_off_req && !hold_off_done) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
        hold_off_done = 1'b1;
      end
      out_ready_i <= 1'b1;
      run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                            : $urandom_range(1, 20);
      repeat (run_len) @(posedge clk_i);
      stall_len = pick_gap();
      if (stall_len > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall_len) @(posedge clk_i);
      end
    end
  end

  initial begin : value_driver
    logic [31:0] corner_values [20];
    board = new();
    corner_values = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'd9, -32'sd9, 32'd10, -32'sd10,
                      32'd99, 32'd100, -32'sd100, 32'd12345, -32'sd67890,
                      32'd999999999, 32'd1000000000, -32'sd1000000000,
                      32'h7FFF_FFFF, 32'h8000_0001, 32'h8000_0000,
                      32'h7FFF_FFFE, 32'd1234567890};
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (corner_values[i]) send_value(corner_values[i]);

    for (int n = 0; n < RANDOM_WORDS; n++) begin
      // every fourth block of fifty words goes without input gaps
      quiet_input = ((n / 50) % 4 == 3);
      if (n == 120) hold_off_req = 1'b1;
      send_value(random_value());
    end
    in_valid_i <= 1'b0;
    // let the final accepted word reach the scoreboard first
    @(posedge clk_i);

    while (board.pending_chars.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (board.errors == 0 && board.pending_chars.size() == 0) begin
      $display("PASS signed_int_to_decimal_ascii_unit");
    end else begin
      $display("FAIL signed_int_to_decimal_ascii_unit");
    end
    $finish;
  end

endmodule
